[rtl/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i8mp_pkg.sv]
// Shared constants, types and register codes for the int8 max-pool block.
// No dependencies.
`timescale 1ns / 1ps

package i8mp_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int CHAN_W       = 8;
    localparam int MAX_CHANNELS = 256;
    localparam int CH_AW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Result queue behind the merge stage
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = OQ_AW + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CHAN_W-1:0]          t_channel;

    localparam t_sample OUT_MIN_RST = 8'sh80;
    localparam t_sample OUT_MAX_RST = 8'sh7f;

    typedef struct packed {
        t_sample  pooled;
        t_channel out_channel;
    } t_result;

    typedef struct packed {
        logic [OQ_CW-1:0] count;
        logic             full;
    } t_oq_status;

endpackage

[rtl/i8mp_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Read returns the old contents when read and write hit the same entry. No dependencies.
`timescale 1ns / 1ps

module i8mp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]                              o_rd_data,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]                              i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/i8mp_outq.sv]
// Small result queue that parts the merge stage from the output handshake.
// Depends on i8mp_pkg.
`timescale 1ns / 1ps

module i8mp_outq
    import i8mp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_sample    o_pooled,
    output t_channel   o_out_channel,
    output t_oq_status o_status
);

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr_ptr;
    logic [OQ_AW-1:0] r_rd_ptr;
    logic [OQ_CW-1:0] r_count;
    logic [OQ_CW-1:0] n_count;
    logic             pop;

    assign pop = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + OQ_CW'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - OQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OQ_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OQ_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid         = (r_count != '0);
    assign o_pooled        = r_mem[r_rd_ptr].pooled;
    assign o_out_channel   = r_mem[r_rd_ptr].out_channel;
    assign o_status.count  = r_count;
    assign o_status.full   = (r_count == OQ_CW'(OQ_DEPTH));

endmodule

[rtl/int8_max_pool_clamp.sv]
// Top level of the int8 max-pool block: running-max store, merge stage, clamp, result queue.
// Depends on i8mp_pkg, i8mp_ram, i8mp_outq and assert_macros.svh.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+------------------------------------
//   input    | in        | i_valid / o_ready          | i_sample, i_channel, i_first/last_of_window
//   result   | out       | o_valid / i_ready          | o_pooled, o_out_channel
//   config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle while o_ready is high. The store read is issued on the input transfer, the
// merge and write-back happen the next cycle; a write-to-read forward covers the same channel
// back to back. Last-of-window results go from the merge stage into the queue, raising o_valid.
// o_ready drops when the result queue plus the item in the merge stage would fill it.
// Reset clears control and sets the clamp bounds to -128 and 127; the store has no clearing
// pass and is undefined until written. Configuration writes are always taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module int8_max_pool_clamp
    import i8mp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_sample              i_sample,
    input  t_channel             i_channel,
    input  logic                 i_first_of_window,
    input  logic                 i_last_of_window,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_sample              o_pooled,
    output t_channel             o_out_channel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_sample              i_cfg_data
);

    t_sample          r_out_min;
    t_sample          r_out_max;

    // Merge stage
    logic             r_s1_valid;
    t_sample          r_s1_sample;
    logic [CH_AW-1:0] r_s1_addr;
    t_channel         r_s1_channel;
    logic             r_s1_first;
    logic             r_s1_last;

    // Last write-back, for a read issued in the same cycle
    logic             r_fwd_valid;
    logic [CH_AW-1:0] r_fwd_addr;
    t_sample          r_fwd_data;

    logic             in_xfer;
    logic             in_range;
    logic [CH_AW-1:0] in_addr;
    logic [SAMPLE_W-1:0] rd_data;
    t_sample          stored;
    t_sample          merged;
    t_sample          raised;
    t_sample          clamped;
    logic             s1_push;
    t_result          push_data;
    t_oq_status       oq_status;

    assign in_xfer  = i_valid && o_ready;
    assign in_range = (32'(i_channel) < MAX_CHANNELS);
    assign in_addr  = CH_AW'(i_channel);
    assign s1_push  = r_s1_valid && r_s1_last;

    // Hold off while the queue could not absorb this item's result.
    assign o_ready     = ((oq_status.count + OQ_CW'(s1_push)) < OQ_CW'(OQ_DEPTH));
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_min <= OUT_MIN_RST;
            r_out_max <= OUT_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OUT_MIN: r_out_min <= i_cfg_data;
                CFG_OUT_MAX: r_out_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    i8mp_ram #(
        .DEPTH (MAX_CHANNELS),
        .WIDTH (SAMPLE_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            // Drop items whose channel lies beyond the store.
            r_s1_valid  <= in_xfer && in_range;
            r_fwd_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_sample  <= i_sample;
            r_s1_addr    <= in_addr;
            r_s1_channel <= i_channel;
            r_s1_first   <= i_first_of_window;
            r_s1_last    <= i_last_of_window;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= merged;
    end

    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            stored = r_fwd_data;
        end else begin
            stored = t_sample'(rd_data);
        end

        if (r_s1_first || (r_s1_sample > stored)) begin
            merged = r_s1_sample;
        end else begin
            merged = stored;
        end

        // Raise to the lower bound first, then lower to the upper bound.
        raised  = (merged < r_out_min) ? r_out_min : merged;
        clamped = (raised > r_out_max) ? r_out_max : raised;

        push_data.pooled      = clamped;
        push_data.out_channel = r_s1_channel;
    end

    i8mp_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (s1_push),
        .i_data        (push_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pooled      (o_pooled),
        .o_out_channel (o_out_channel),
        .o_status      (oq_status)
    );

    `ASSERT_ALWAYS(a_no_push_when_full, !(s1_push && oq_status.full), "push into full queue")
    `ASSERT_NEXT(a_last_gives_push, in_xfer && in_range && i_last_of_window, s1_push, "lost result")
    `ASSERT_ALWAYS(a_valid_tracks_count, o_valid == (oq_status.count != '0), "valid vs count")

endmodule
